>>> design/ohdm_pkg.sv
// Package for the omni drive heading mixer: shared types, register indexes,
// reset values, fixed-point constants and the sector drive table.
// No dependencies.
`timescale 1ns / 1ps

package ohdm_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BATTERY_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_HEADING_CENTER    = 2'd1;
   localparam logic [1:0] CSR_HEADING_LIMIT     = 2'd2;
   localparam logic [1:0] CSR_RECOVERY_DRIVE    = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [7:0] BATTERY_THRESHOLD_RESET = 8'd95;
   localparam logic [8:0] HEADING_CENTER_RESET    = 9'd180;
   localparam logic [7:0] HEADING_LIMIT_RESET     = 8'd100;
   localparam logic [6:0] RECOVERY_DRIVE_RESET    = 7'd90;

   // Highest travel sector that produces a result.
   localparam logic [3:0] SECTOR_LAST = 4'd11;

   // heading / 10 as (heading * 52429) >> 19, exact for 12-bit headings.
   localparam logic [15:0] TENTH_RECIP = 16'd52429;
   localparam int          TENTH_SHIFT = 19;

   // mag * 255 / 100 as (mag * 1336965) >> 19, exact for mag below 100.
   localparam logic [20:0] DUTY_RECIP = 21'd1336965;
   localparam int          DUTY_SHIFT = 19;
   localparam logic [9:0]  DUTY_SAT_MAG = 10'd100;
   localparam logic [7:0]  DUTY_MAX = 8'd255;

   // Wheel coefficient in units of power/2: +2, +1, 0, -1, -2.
   typedef logic signed [2:0] coef_type;

   localparam coef_type COEF_FULL_POS = 3'sd2;
   localparam coef_type COEF_HALF_POS = 3'sd1;
   localparam coef_type COEF_ZERO     = 3'sd0;
   localparam coef_type COEF_HALF_NEG = -3'sd1;
   localparam coef_type COEF_FULL_NEG = -3'sd2;

   typedef struct packed {
      coef_type a;
      coef_type b;
      coef_type c;
   } coef_set_type;

   // Registered input transaction.
   typedef struct packed {
      logic [3:0] direction;
      logic [6:0] power;
      logic [8:0] heading_deg;
      logic [7:0] battery_level;
   } item_type;

   // Heading correction mode shared by all three wheels.
   typedef struct packed {
      logic spin_fwd;
      logic spin_rev;
   } spin_type;

   function automatic coef_set_type sector_coefs(input logic [3:0] sector);
      coef_set_type coefs;
      unique case (sector)
         4'd0:    coefs = '{COEF_FULL_POS, COEF_ZERO,     COEF_FULL_NEG};
         4'd1:    coefs = '{COEF_HALF_POS, COEF_HALF_POS, COEF_FULL_NEG};
         4'd2:    coefs = '{COEF_ZERO,     COEF_FULL_POS, COEF_FULL_NEG};
         4'd3:    coefs = '{COEF_HALF_NEG, COEF_FULL_POS, COEF_HALF_NEG};
         4'd4:    coefs = '{COEF_FULL_NEG, COEF_FULL_POS, COEF_ZERO};
         4'd5:    coefs = '{COEF_FULL_NEG, COEF_HALF_POS, COEF_HALF_POS};
         4'd6:    coefs = '{COEF_FULL_NEG, COEF_ZERO,     COEF_FULL_POS};
         4'd7:    coefs = '{COEF_HALF_NEG, COEF_HALF_NEG, COEF_FULL_POS};
         4'd8:    coefs = '{COEF_ZERO,     COEF_FULL_NEG, COEF_FULL_POS};
         4'd9:    coefs = '{COEF_HALF_POS, COEF_FULL_NEG, COEF_HALF_POS};
         4'd10:   coefs = '{COEF_FULL_POS, COEF_FULL_NEG, COEF_ZERO};
         4'd11:   coefs = '{COEF_FULL_POS, COEF_HALF_NEG, COEF_HALF_NEG};
         default: coefs = '{COEF_ZERO,     COEF_ZERO,     COEF_ZERO};
      endcase
      return coefs;
   endfunction

endpackage

>>> design/omni_drive_heading_mixer_unit.sv
// Top level of the omni drive heading mixer: configuration registers, the
// fault latch, three wheel mixers and the result register.
// Depends on ohdm_pkg, ohdm_input_stage and ohdm_wheel.
`timescale 1ns / 1ps

// Usage:
// A request transaction carries a travel sector, a power level, a compass
// heading in tenths of a degree and a battery reading. Each request with a
// sector of 0 to 11 yields exactly one response transaction with three wheel
// duties, three reverse bits and the low battery flag. Requests with a sector
// above 11 are accepted and dropped without a response.
// Path: the edge that accepts a request loads the input register (where
// the heading is cut to whole degrees); the result register loads when the
// input register moves on, and rsp_valid rises with it.
// Throughput is one transaction per cycle; the block
// keeps taking requests while a response waits, as long as the input
// register can move on. When the receiver stalls, the result register holds
// and the input register fills, after which req_ready drops until rsp_ready
// returns.
// Reset clears both pipeline stages, the low battery fault latch and loads
// the configuration registers with their default values. Once latched, the
// fault stays set until reset and forces all duties and reverse bits to zero.
// Configuration writes take effect at once and are meant to happen only while
// no transaction is in flight.

module omni_drive_heading_mixer_unit (
   input  logic        clock,
   input  logic        reset,
   // Configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_write_data,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_direction,
   input  logic [6:0]  req_power,
   input  logic [11:0] req_heading,
   input  logic [7:0]  req_battery_level,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_duty_a,
   output logic        rsp_reverse_a,
   output logic [7:0]  rsp_duty_b,
   output logic        rsp_reverse_b,
   output logic [7:0]  rsp_duty_c,
   output logic        rsp_reverse_c,
   output logic        rsp_low_battery
);

   // Configuration registers.
   logic [7:0] battery_threshold_ff;
   logic [8:0] heading_center_ff;
   logic [7:0] heading_limit_ff;
   logic [6:0] recovery_drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         battery_threshold_ff <= ohdm_pkg::BATTERY_THRESHOLD_RESET;
         heading_center_ff    <= ohdm_pkg::HEADING_CENTER_RESET;
         heading_limit_ff     <= ohdm_pkg::HEADING_LIMIT_RESET;
         recovery_drive_ff    <= ohdm_pkg::RECOVERY_DRIVE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ohdm_pkg::CSR_BATTERY_THRESHOLD: battery_threshold_ff <= csr_write_data[7:0];
            ohdm_pkg::CSR_HEADING_CENTER:    heading_center_ff    <= csr_write_data;
            ohdm_pkg::CSR_HEADING_LIMIT:     heading_limit_ff     <= csr_write_data[7:0];
            ohdm_pkg::CSR_RECOVERY_DRIVE:    recovery_drive_ff    <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // Input register stage.
   logic               item_valid;
   ohdm_pkg::item_type item;
   logic               advance;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   // The input register moves on whenever the result register is empty or
   // its transaction is being taken this cycle.
   assign advance = item_valid && (!rsp_valid_ff || rsp_ready);

   ohdm_input_stage u_input_stage (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_direction     (req_direction),
      .req_power         (req_power),
      .req_heading       (req_heading),
      .req_battery_level (req_battery_level),
      .advance           (advance),
      .item_valid        (item_valid),
      .item              (item)
   );

   // Fault latch. The battery check of the current transaction counts for
   // its own response, so the forced-zero condition looks at both.
   logic fault_ff;
   logic fault_in;
   logic battery_low;
   logic fault_now;

   assign battery_low = item.battery_level < battery_threshold_ff;
   assign fault_now   = fault_ff || battery_low;
   assign fault_in    = fault_ff || (advance && battery_low);

   // Heading error in whole degrees and the spin recovery decision.
   logic signed [10:0]     heading_err;
   logic signed [10:0]     limit_pos;
   ohdm_pkg::spin_type     spin;
   ohdm_pkg::coef_set_type coefs;

   always_comb begin
      heading_err   = $signed({2'b00, item.heading_deg}) - $signed({2'b00, heading_center_ff});
      limit_pos     = $signed({3'b000, heading_limit_ff});
      spin.spin_fwd = heading_err > limit_pos;
      spin.spin_rev = heading_err < -limit_pos;
      coefs         = ohdm_pkg::sector_coefs(item.direction);
   end

   logic [7:0] duty_a;
   logic [7:0] duty_b;
   logic [7:0] duty_c;
   logic       reverse_a;
   logic       reverse_b;
   logic       reverse_c;

   ohdm_wheel u_wheel_a (
      .coef           (coefs.a),
      .power          (item.power),
      .heading_err    (heading_err),
      .spin           (spin),
      .recovery_drive (recovery_drive_ff),
      .duty           (duty_a),
      .reverse        (reverse_a)
   );

   ohdm_wheel u_wheel_b (
      .coef           (coefs.b),
      .power          (item.power),
      .heading_err    (heading_err),
      .spin           (spin),
      .recovery_drive (recovery_drive_ff),
      .duty           (duty_b),
      .reverse        (reverse_b)
   );

   ohdm_wheel u_wheel_c (
      .coef           (coefs.c),
      .power          (item.power),
      .heading_err    (heading_err),
      .spin           (spin),
      .recovery_drive (recovery_drive_ff),
      .duty           (duty_c),
      .reverse        (reverse_c)
   );

   // Result register.
   logic [7:0] duty_a_ff;
   logic [7:0] duty_b_ff;
   logic [7:0] duty_c_ff;
   logic       reverse_a_ff;
   logic       reverse_b_ff;
   logic       reverse_c_ff;
   logic       low_battery_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fault_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fault_ff     <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         duty_a_ff      <= fault_now ? 8'd0 : duty_a;
         duty_b_ff      <= fault_now ? 8'd0 : duty_b;
         duty_c_ff      <= fault_now ? 8'd0 : duty_c;
         reverse_a_ff   <= !fault_now && reverse_a;
         reverse_b_ff   <= !fault_now && reverse_b;
         reverse_c_ff   <= !fault_now && reverse_c;
         low_battery_ff <= fault_now;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_a      = duty_a_ff;
   assign rsp_reverse_a   = reverse_a_ff;
   assign rsp_duty_b      = duty_b_ff;
   assign rsp_reverse_b   = reverse_b_ff;
   assign rsp_duty_c      = duty_c_ff;
   assign rsp_reverse_c   = reverse_c_ff;
   assign rsp_low_battery = low_battery_ff;

endmodule

>>> design/ohdm_input_stage.sv
// Input register stage of the omni drive heading mixer. Converts the heading
// to whole degrees and drops transactions with an unused sector.
// Depends on ohdm_pkg.
`timescale 1ns / 1ps

module ohdm_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_direction,
   input  logic [6:0]        req_power,
   input  logic [11:0]       req_heading,
   input  logic [7:0]        req_battery_level,
   input  logic              advance,
   output logic              item_valid,
   output ohdm_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   ohdm_pkg::item_type item_ff;
   ohdm_pkg::item_type item_in;
   logic [27:0]        tenth_prod;
   logic               load;

   assign req_ready = !valid_ff || advance;
   assign load      = req_valid && req_ready && (req_direction <= ohdm_pkg::SECTOR_LAST);

   assign tenth_prod = {16'd0, req_heading} * {12'd0, ohdm_pkg::TENTH_RECIP};

   always_comb begin
      item_in.direction     = req_direction;
      item_in.power         = req_power;
      item_in.heading_deg   = tenth_prod[ohdm_pkg::TENTH_SHIFT +: 9];
      item_in.battery_level = req_battery_level;
      valid_in              = load || (valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/ohdm_wheel.sv
// One wheel of the omni drive heading mixer: table drive plus heading
// correction, then magnitude scaling to a pwm duty and a reverse bit.
// Depends on ohdm_pkg.
`timescale 1ns / 1ps

module ohdm_wheel (
   input  ohdm_pkg::coef_type coef,
   input  logic [6:0]         power,
   input  logic signed [10:0] heading_err,
   input  ohdm_pkg::spin_type spin,
   input  logic [6:0]         recovery_drive,
   output logic [7:0]         duty,
   output logic               reverse
);

   logic signed [8:0]  base;
   logic signed [11:0] sum;
   logic signed [11:0] sum_adj;
   logic signed [10:0] mix_drive;
   logic signed [10:0] drive;
   logic [10:0]        mag;
   logic [27:0]        duty_prod;

   always_comb begin
      unique case (coef)
         ohdm_pkg::COEF_FULL_POS: base = $signed({2'b00, power});
         ohdm_pkg::COEF_HALF_POS: base = $signed({3'b000, power[6:1]});
         ohdm_pkg::COEF_HALF_NEG: base = -$signed({3'b000, power[6:1]});
         ohdm_pkg::COEF_FULL_NEG: base = -$signed({2'b00, power});
         default:                 base = 9'sd0;
      endcase

      // Half-percent sum, halved with truncation toward zero.
      sum       = $signed({{2{base[8]}}, base, 1'b0}) + $signed({heading_err[10], heading_err});
      sum_adj   = sum + $signed({11'd0, sum[11]});
      mix_drive = sum_adj[11:1];

      priority if (spin.spin_fwd) begin
         drive = $signed({4'd0, recovery_drive});
      end else if (spin.spin_rev) begin
         drive = -$signed({4'd0, recovery_drive});
      end else begin
         drive = mix_drive;
      end

      mag       = drive[10] ? 11'(-drive) : 11'(drive);
      duty_prod = {21'd0, mag[6:0]} * {7'd0, ohdm_pkg::DUTY_RECIP};

      if (mag[9:0] >= ohdm_pkg::DUTY_SAT_MAG || mag[10]) begin
         duty = ohdm_pkg::DUTY_MAX;
      end else begin
         duty = duty_prod[ohdm_pkg::DUTY_SHIFT +: 8];
      end
      reverse = drive[10];
   end

endmodule
